/* hw/rtl/wrsa_pkg.sv */
// Package for the work ring slot allocator.
// Holds widths, operation codes and the request/result structs.
// No dependencies; used by every other file of the block.
package wrsa_pkg;

	// Ring geometry
	localparam int unsigned MAX_SLOTS = 4096;
	localparam int unsigned POS_W     = $clog2(MAX_SLOTS);
	localparam int unsigned CNT_W     = POS_W + 1;
	localparam int unsigned FUNC_W    = 3;

	localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(MAX_SLOTS);
	localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(1);
	localparam logic [CNT_W-1:0] RING_SIZE_RST = CNT_W'(MAX_SLOTS);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_PARTIAL   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_EXACT     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNALLOC   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_COMPLETED = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CNT_W-1:0]  count;
		logic [POS_W-1:0]  work_id;
		logic [POS_W-1:0]  oldest_given;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] granted;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] used;
		logic             empty_res;
		logic             low_mark;
		logic [POS_W-1:0] oldest_slot;
		logic [CNT_W-1:0] completed;
		logic             error;
	} rsp_t;

	// Handshake between the input register and the result register
	typedef struct packed {
		logic valid;
		logic take;
	} stage_ctl_t;

endpackage

/* hw/rtl/wrsa_req_if.sv */
// Request channel of the work ring slot allocator.
// Depends on wrsa_pkg for field widths.
interface wrsa_req_if;
	logic                          valid;
	logic                          ready;
	logic [wrsa_pkg::FUNC_W-1:0]   func;
	logic [wrsa_pkg::CNT_W-1:0]    count;
	logic [wrsa_pkg::POS_W-1:0]    work_id;
	logic [wrsa_pkg::POS_W-1:0]    oldest_given;

	modport source(output valid, func, count, work_id, oldest_given, input ready);
	modport sink(input valid, func, count, work_id, oldest_given, output ready);
endinterface

/* hw/rtl/wrsa_rsp_if.sv */
// Result channel of the work ring slot allocator.
// Depends on wrsa_pkg for field widths.
interface wrsa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [wrsa_pkg::CNT_W-1:0] granted;
	logic [wrsa_pkg::POS_W-1:0] position;
	logic [wrsa_pkg::CNT_W-1:0] used;
	logic                       empty_res;
	logic                       low_mark;
	logic [wrsa_pkg::POS_W-1:0] oldest_slot;
	logic [wrsa_pkg::CNT_W-1:0] completed;
	logic                       error;

	modport source(output valid, granted, position, used, empty_res, low_mark,
		oldest_slot, completed, error, input ready);
	modport sink(input valid, granted, position, used, empty_res, low_mark,
		oldest_slot, completed, error, output ready);
endinterface

/* hw/rtl/wrsa_cfg_if.sv */
// Configuration write channel (ring size) of the work ring slot allocator.
// Depends on wrsa_pkg for the register width.
interface wrsa_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [wrsa_pkg::CNT_W-1:0] ring_size;

	modport source(output valid, ring_size, input ready);
	modport sink(input valid, ring_size, output ready);
endinterface

/* hw/rtl/wrsa_in_stage.sv */
// Input register of the work ring slot allocator.
// Depends on wrsa_pkg and wrsa_req_if.
module wrsa_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	wrsa_req_if.sink              req,
	input  logic                  take,
	output wrsa_pkg::stage_ctl_t  ctl,
	output wrsa_pkg::req_t        req_s1
);

	logic valid_s1;

	// Room when empty or when the held request moves on this cycle
	assign req.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.func         <= req.func;
			req_s1.count        <= req.count;
			req_s1.work_id      <= req.work_id;
			req_s1.oldest_given <= req.oldest_given;
		end
	end

	assign ctl.valid = valid_s1;
	assign ctl.take  = take;

endmodule

/* hw/rtl/wrsa_core.sv */
// Ring state and operation logic of the work ring slot allocator.
// Holds ring size, positions and used count; computes one result per transfer.
// Depends on wrsa_pkg and wrsa_cfg_if.
module wrsa_core (
	input  logic                 clk,
	input  logic                 arst_n,
	wrsa_cfg_if.sink             cfg,
	input  wrsa_pkg::stage_ctl_t ctl,
	input  wrsa_pkg::req_t       req_s1,
	output wrsa_pkg::rsp_t       res
);

	logic [wrsa_pkg::CNT_W-1:0] ring_size_q;
	logic [wrsa_pkg::POS_W-1:0] alloc_pos_q;
	logic [wrsa_pkg::POS_W-1:0] free_pos_q;
	logic [wrsa_pkg::CNT_W-1:0] used_q;

	logic [wrsa_pkg::CNT_W-1:0] size;
	logic [wrsa_pkg::CNT_W-1:0] avail;
	logic [wrsa_pkg::CNT_W-1:0] granted;
	logic [wrsa_pkg::CNT_W-1:0] completed;
	logic                       over;
	logic                       err;
	logic [wrsa_pkg::CNT_W-1:0] grant_sum;
	logic [wrsa_pkg::CNT_W-1:0] back_sum;
	logic [wrsa_pkg::CNT_W-1:0] free_sum;
	logic [wrsa_pkg::POS_W-1:0] alloc_pos_d;
	logic [wrsa_pkg::POS_W-1:0] free_pos_d;
	logic [wrsa_pkg::CNT_W-1:0] used_d;
	logic                       fire;

	assign fire      = ctl.valid && ctl.take;
	assign cfg.ready = 1'b1;

	// Effective ring size: zero acts as one, clamp at the maximum
	always_comb begin
		if (ring_size_q == '0) begin
			size = wrsa_pkg::SIZE_MIN;
		end else if (ring_size_q > wrsa_pkg::SIZE_MAX) begin
			size = wrsa_pkg::SIZE_MAX;
		end else begin
			size = ring_size_q;
		end
	end

	// used never exceeds size, so no underflow here
	assign avail = size - used_q;
	assign over  = req_s1.count > used_q;

	// Position sums stay below twice the size: one conditional subtract wraps them
	assign grant_sum = {1'b0, alloc_pos_q} + granted;
	assign back_sum  = {1'b0, alloc_pos_q} + size - req_s1.count;
	assign free_sum  = {1'b0, free_pos_q} + req_s1.count;

	// Operation decode
	always_comb begin
		granted     = '0;
		completed   = '0;
		err         = 1'b0;
		alloc_pos_d = alloc_pos_q;
		free_pos_d  = free_pos_q;
		used_d      = used_q;
		case (req_s1.func)
			wrsa_pkg::FUNC_PARTIAL, wrsa_pkg::FUNC_EXACT: begin
				if (req_s1.count <= avail) begin
					granted = req_s1.count;
				end else if (req_s1.func == wrsa_pkg::FUNC_PARTIAL) begin
					granted = avail;
				end
				alloc_pos_d = (grant_sum >= size) ? wrsa_pkg::POS_W'(grant_sum - size)
					: grant_sum[wrsa_pkg::POS_W-1:0];
				used_d = used_q + granted;
			end
			wrsa_pkg::FUNC_FREE: begin
				if (over) begin
					err = 1'b1;
				end else begin
					free_pos_d = (free_sum >= size) ? wrsa_pkg::POS_W'(free_sum - size)
						: free_sum[wrsa_pkg::POS_W-1:0];
					used_d = used_q - req_s1.count;
				end
			end
			wrsa_pkg::FUNC_UNALLOC: begin
				if (over) begin
					err = 1'b1;
				end else begin
					alloc_pos_d = (back_sum >= size) ? wrsa_pkg::POS_W'(back_sum - size)
						: back_sum[wrsa_pkg::POS_W-1:0];
					used_d = used_q - req_s1.count;
				end
			end
			wrsa_pkg::FUNC_COMPLETED: begin
				// Inclusive span from oldest to work_id, wrapping at the ring end
				if (req_s1.oldest_given <= req_s1.work_id) begin
					completed = {1'b0, req_s1.work_id} - {1'b0, req_s1.oldest_given}
						+ wrsa_pkg::CNT_W'(1);
				end else begin
					completed = size - {1'b0, req_s1.oldest_given} + {1'b0, req_s1.work_id}
						+ wrsa_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Ring state; a size write clears positions and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= wrsa_pkg::RING_SIZE_RST;
			alloc_pos_q <= '0;
			free_pos_q  <= '0;
			used_q      <= '0;
		end else if (cfg.valid && cfg.ready) begin
			ring_size_q <= cfg.ring_size;
			alloc_pos_q <= '0;
			free_pos_q  <= '0;
			used_q      <= '0;
		end else if (fire) begin
			alloc_pos_q <= alloc_pos_d;
			free_pos_q  <= free_pos_d;
			used_q      <= used_d;
		end
	end

	// Status after the operation; position is the allocation position before it
	assign res.granted     = granted;
	assign res.position    = alloc_pos_q;
	assign res.used        = used_d;
	assign res.empty_res   = (used_d == '0);
	assign res.low_mark    = (used_d <= (size >> 2));
	assign res.oldest_slot = free_pos_d;
	assign res.completed   = completed;
	assign res.error       = err;

endmodule

/* hw/rtl/wrsa_out_stage.sv */
// Result register of the work ring slot allocator.
// Depends on wrsa_pkg and wrsa_rsp_if.
module wrsa_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wrsa_pkg::rsp_t res,
	output logic           can_take,
	wrsa_rsp_if.source     rsp
);

	logic           valid_q;
	wrsa_pkg::rsp_t res_q;

	// Free when empty or the held result is transferred this cycle
	assign can_take = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_take) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.granted     = res_q.granted;
	assign rsp.position    = res_q.position;
	assign rsp.used        = res_q.used;
	assign rsp.empty_res   = res_q.empty_res;
	assign rsp.low_mark    = res_q.low_mark;
	assign rsp.oldest_slot = res_q.oldest_slot;
	assign rsp.completed   = res_q.completed;
	assign rsp.error       = res_q.error;

endmodule

/* hw/rtl/work_ring_slot_allocator_top.sv */
// Work ring slot allocator, top level.
// Path: a request transfer enters the input register, then passes through the operation
// logic into the result register, which offers it on the result channel.
// Throughput: one request per cycle unless rsp stalls; the ring state updates in the same cycle.
// Reset: ring size 4096, positions and used count zero; no clearing pass.
module work_ring_slot_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	wrsa_req_if.sink   req,
	wrsa_rsp_if.source rsp,
	wrsa_cfg_if.sink   cfg
);

	wrsa_pkg::stage_ctl_t ctl;
	wrsa_pkg::req_t       req_s1;
	wrsa_pkg::rsp_t       res;
	logic                 can_take;

	wrsa_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (can_take),
		.ctl    (ctl),
		.req_s1 (req_s1)
	);

	wrsa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctl    (ctl),
		.req_s1 (req_s1),
		.res    (res)
	);

	wrsa_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctl.valid),
		.res      (res),
		.can_take (can_take),
		.rsp      (rsp)
	);

	// A held request is not dropped while the result register is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid && !can_take |=> ctl.valid)
		else $error("input register lost a request under stall");

	// Empty flag tracks the used count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.empty_res == (rsp.used == '0)))
		else $error("empty flag disagrees with used count");

	// A rejected free or unalloc never grants slots or counts completions
	a_err_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error |-> (rsp.granted == '0) && (rsp.completed == '0))
		else $error("error result carries a grant or completion count");

	// Used count never exceeds the largest ring
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.used <= wrsa_pkg::SIZE_MAX)
		else $error("used count beyond ring capacity");

endmodule
